>>> hw/rtl/lss_pkg.sv
// Shared types, constants and control structs for the search stack.
package lss_pkg;

    localparam int DATA_W    = 32;
    localparam int CMD_W     = 2;
    localparam int POS_W     = 6;
    localparam int STATUS_W  = 2;
    localparam int DEPTH_DEF = 64;

    // Request operation codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_SEARCH = 2'd3
    } t_cmd;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN
    } t_state;

    // Kind of result loaded into the output register
    typedef enum logic [2:0] {
        RES_PUSH_OK,
        RES_FULL,
        RES_EMPTY,
        RES_TOP,
        RES_HIT,
        RES_MISS
    } t_res;

    // Controller to datapath commands
    typedef struct packed {
        logic push;        // write value on top, count up
        logic rd_top;      // read the top entry
        logic pop;         // count down
        logic scan_start;  // latch key, rewind scan
        logic scan_step;   // issue next scan read, compare last one
        logic load;        // load output register
        t_res res;         // what to load
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic full;
        logic empty;
        logic hit;   // compared entry equals key
        logic last;  // compared entry is the top one
    } t_dp_sts;

endpackage

>>> hw/rtl/lss_if.sv
// Request and response channel interfaces for the search stack.
interface lss_req_if;
    import lss_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface lss_rsp_if;
    import lss_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] data;
    logic                     found;
    logic [POS_W-1:0]         position;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, output data, output found, output position,
                    output status, input ready);
    modport sink   (input valid, input data, input found, input position,
                    input status, output ready);
endinterface

>>> hw/rtl/lss_ram.sv
// Generic single write port, single read port RAM with registered read.
module lss_ram #(
    parameter int  WIDTH  = 32,
    parameter int  DEPTH  = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/lss_dp.sv
// Datapath: entry count, stack memory, search scan and output register.
module lss_dp #(
    parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lss_pkg::t_dp_cmd                 i_cmd,
    input  logic signed [lss_pkg::DATA_W-1:0] i_value,
    output lss_pkg::t_dp_sts                 o_sts,
    output logic signed [lss_pkg::DATA_W-1:0] o_data,
    output logic                             o_found,
    output logic [lss_pkg::POS_W-1:0]        o_position,
    output logic [lss_pkg::STATUS_W-1:0]     o_status
);
    import lss_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]             r_count, n_count;
    logic signed [DATA_W-1:0]  r_key;
    logic [CW-1:0]             r_scan_addr, n_scan_addr;
    logic [AW-1:0]             r_cmp_addr, n_cmp_addr;
    logic                      r_cmp_valid, n_cmp_valid;
    logic signed [DATA_W-1:0]  r_data, n_data;
    logic                      r_found, n_found;
    logic [POS_W-1:0]          r_position, n_position;
    t_status                   r_status, n_status;

    logic [AW-1:0]             w_top;
    logic [AW-1:0]             w_raddr;
    logic [DATA_W-1:0]         w_rdata;
    logic                      w_issue;

    assign w_top   = AW'(r_count - CW'(1));
    assign w_issue = (r_scan_addr < r_count);
    assign w_raddr = i_cmd.rd_top ? w_top : r_scan_addr[AW-1:0];

    lss_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Status toward the controller
    always_comb begin
        o_sts.full  = (r_count == CW'(DEPTH));
        o_sts.empty = (r_count == '0);
        o_sts.hit   = r_cmp_valid && (w_rdata == r_key);
        o_sts.last  = r_cmp_valid && (r_cmp_addr == w_top);
    end

    // Advance count and scan pointers
    always_comb begin
        n_count     = r_count;
        n_scan_addr = r_scan_addr;
        n_cmp_addr  = r_cmp_addr;
        n_cmp_valid = 1'b0;
        if (i_cmd.push) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
        end
        if (i_cmd.scan_start) begin
            n_scan_addr = '0;
        end else if (i_cmd.scan_step && w_issue) begin
            n_scan_addr = r_scan_addr + CW'(1);
            n_cmp_addr  = r_scan_addr[AW-1:0];
            n_cmp_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cmp_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_cmp_valid <= n_cmp_valid;
        end
    end

    // Hold key and scan addresses
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_key <= i_value;
        end
        r_scan_addr <= n_scan_addr;
        r_cmp_addr  <= n_cmp_addr;
    end

    // Build the result fields for the kind being loaded
    always_comb begin
        n_data     = '0;
        n_found    = 1'b0;
        n_position = '0;
        n_status   = STATUS_OK;
        unique case (i_cmd.res)
            RES_PUSH_OK: n_status = STATUS_OK;
            RES_FULL:    n_status = STATUS_FULL;
            RES_EMPTY:   n_status = STATUS_EMPTY;
            RES_TOP:     n_data   = w_rdata;
            RES_HIT: begin
                n_found    = 1'b1;
                n_position = POS_W'(r_cmp_addr);
            end
            RES_MISS:    n_status = STATUS_OK;
            default:     n_status = STATUS_OK;
        endcase
    end

    // Load output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_data     <= n_data;
            r_found    <= n_found;
            r_position <= n_position;
            r_status   <= n_status;
        end
    end

    assign o_data     = r_data;
    assign o_found    = r_found;
    assign o_position = r_position;
    assign o_status   = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> !o_sts.full)
        else $error("push issued on a full stack");

    a_cmp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_valid |-> (CW'(r_cmp_addr) < r_count))
        else $error("scan compared an entry above the top");

endmodule

>>> hw/rtl/lss_ctrl.sv
// Controller: request decode, sequencing and output valid.
module lss_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic [lss_pkg::CMD_W-1:0] i_in_cmd,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output lss_pkg::t_dp_cmd         o_cmd,
    input  lss_pkg::t_dp_sts         i_sts
);
    import lss_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    t_cmd   w_cmd;

    assign w_cmd      = t_cmd'(i_in_cmd);
    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_cmd)
                        CMD_PUSH:   n_state = ST_IDLE;
                        CMD_POP,
                        CMD_PEEK:   n_state = i_sts.empty ? ST_IDLE : ST_READ;
                        CMD_SEARCH: n_state = i_sts.empty ? ST_IDLE : ST_SCAN;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_READ: n_state = ST_IDLE;
            ST_SCAN: begin
                if (i_sts.hit || i_sts.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd = '0;
        o_cmd.res = RES_PUSH_OK;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_cmd)
                        CMD_PUSH: begin
                            o_cmd.load = 1'b1;
                            if (i_sts.full) begin
                                o_cmd.res = RES_FULL;
                            end else begin
                                o_cmd.push = 1'b1;
                                o_cmd.res  = RES_PUSH_OK;
                            end
                        end
                        CMD_POP, CMD_PEEK: begin
                            if (i_sts.empty) begin
                                o_cmd.load = 1'b1;
                                o_cmd.res  = RES_EMPTY;
                            end else begin
                                o_cmd.rd_top = 1'b1;
                                o_cmd.pop    = (w_cmd == CMD_POP);
                            end
                        end
                        CMD_SEARCH: begin
                            if (i_sts.empty) begin
                                o_cmd.load = 1'b1;
                                o_cmd.res  = RES_MISS;
                            end else begin
                                o_cmd.scan_start = 1'b1;
                            end
                        end
                        default: o_cmd.load = 1'b0;
                    endcase
                end
            end
            ST_READ: begin
                o_cmd.load = 1'b1;
                o_cmd.res  = RES_TOP;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.hit) begin
                    o_cmd.load = 1'b1;
                    o_cmd.res  = RES_HIT;
                end else if (i_sts.last) begin
                    o_cmd.load = 1'b1;
                    o_cmd.res  = RES_MISS;
                end
            end
            default: o_cmd.load = 1'b0;
        endcase
    end

    // Set valid on load, drop it once the item is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load && r_out_valid && !i_out_ready))
        else $error("result loaded over an item not yet taken");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_in_ready)
        else $error("request taken while busy");

    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> ((r_state == ST_IDLE) && r_out_valid))
        else $error("top read did not produce a result");

endmodule

>>> hw/rtl/lifo_stack_with_search.sv
// Top level of the LIFO stack with linear search.
//
//  channel | dir | handshake       | payload
//  i_req   | in  | valid / ready   | cmd[1:0], value[31:0] signed
//  o_rsp   | out | valid / ready   | data[31:0] signed, found, position[5:0], status[1:0]
//
// Push, a refused push, an empty pop or peek, and a search of an empty stack
// load the output register when accepted; pop and peek pass through a read
// state for the registered RAM read. A search compares at most the entry
// count of entries, one compare per cycle through the single RAM read port.
// Reset clears the entry count and the handshake state; the memory is not
// cleared. i_req.ready is low while an item is in work, or while a result
// waits in the output register and o_rsp.ready is low.
module lifo_stack_with_search #(
    parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    lss_req_if.sink  i_req,
    lss_rsp_if.source o_rsp
);
    import lss_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    lss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_in_cmd    (i_req.cmd),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    lss_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_value    (i_req.value),
        .o_sts      (w_sts),
        .o_data     (o_rsp.data),
        .o_found    (o_rsp.found),
        .o_position (o_rsp.position),
        .o_status   (o_rsp.status)
    );

endmodule
